// ===== rtl/core/spwa_pkg.sv =====
// spwa_pkg: shared constants, codes and types of the spectrum peak weighted accumulator
// no dependencies; used by the interfaces, the accumulator and spwa_div in rtl/core
package spwa_pkg;

    localparam int MAX_BINS   = 129;
    localparam int BIN_W      = 8;
    localparam int ADDR_W     = $clog2(MAX_BINS);
    localparam int POWER_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int PACC_W     = 64;
    localparam int WACC_W     = 40;
    localparam int MEAN_W     = 32;
    localparam int PROD_W     = POWER_W + FRAC_W;
    localparam int SUM_W      = POWER_W + 2;
    localparam int REM_W      = WACC_W + 1;
    localparam int STEP_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b1;

    localparam logic ACT_PUSH     = 1'b0;
    localparam logic ACT_READ     = 1'b1;
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_ADDR,
        S_SUM_DATA,
        S_FR_ADDR,
        S_FR_DATA,
        S_FR_DIV,
        S_MUL,
        S_UPD,
        S_RD_DATA,
        S_RD_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                 kind;
        logic [BIN_W-1:0]     peak_bin;
        logic [POWER_W-1:0]   peak_power;
        logic                 peak_passed;
        logic [PACC_W-1:0]    weighted_power_sum;
        logic [WACC_W-1:0]    weight_sum;
        logic [MEAN_W-1:0]    mean_power;
    } t_result;

    typedef struct packed {
        logic                 start;
        logic [REM_W-1:0]     rem;
        logic [MEAN_W-1:0]    dvd;
        logic [WACC_W-1:0]    dvs;
        logic [STEP_W-1:0]    steps;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [MEAN_W-1:0]    quot;
    } t_div_rsp;

endpackage

// ===== rtl/core/spwa_in_if.sv =====
// spwa_in_if: input channel, valid/ready handshake with the bin or read request
// depends on spwa_pkg for field widths
interface spwa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [spwa_pkg::POWER_W-1:0]  bin_power;
    logic [spwa_pkg::BIN_W-1:0]    read_bin;

    modport source (output valid, action, bin_power, read_bin, input ready);
    modport sink   (input valid, action, bin_power, read_bin, output ready);
endinterface

// ===== rtl/core/spwa_out_if.sv =====
// spwa_out_if: result channel, valid/ready handshake with report or readout fields
// depends on spwa_pkg for field widths
interface spwa_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [spwa_pkg::BIN_W-1:0]    peak_bin;
    logic [spwa_pkg::POWER_W-1:0]  peak_power;
    logic                          peak_passed;
    logic [spwa_pkg::PACC_W-1:0]   weighted_power_sum;
    logic [spwa_pkg::WACC_W-1:0]   weight_sum;
    logic [spwa_pkg::MEAN_W-1:0]   mean_power;

    modport source (output valid, kind, peak_bin, peak_power, peak_passed,
                    weighted_power_sum, weight_sum, mean_power, input ready);
    modport sink   (input valid, kind, peak_bin, peak_power, peak_passed,
                    weighted_power_sum, weight_sum, mean_power, output ready);
endinterface

// ===== rtl/core/spectrum_peak_weighted_accumulator.sv =====
// spectrum_peak_weighted_accumulator: a push of a bin updates the running peak; a row end
// without a passed peak goes straight to its report; a passed peak runs up to three
// fraction divisions before its report, and a readout runs up to one division.
// one item at a time; both kinds of division use the one shared divider
// synchronous active-low reset clears row state and accumulator valid bits and sets the
// threshold and row-length registers to their defaults; no clearing pass is needed
module spectrum_peak_weighted_accumulator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    spwa_in_if.sink                         i_in,
    spwa_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [spwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spwa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spwa_pkg::*;

    t_state             r_state, n_state;
    logic [POWER_W-1:0] r_thresh;
    logic [BIN_W-1:0]   r_row_len;
    logic [BIN_W-1:0]   r_pos, n_pos;
    logic [BIN_W-1:0]   r_pk_bin, n_pk_bin;
    logic [POWER_W-1:0] r_pk_pow, n_pk_pow;
    logic [BIN_W-1:0]   r_centre, n_centre;
    logic [1:0]         r_k, n_k;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [POWER_W-1:0] r_x, n_x;
    logic [FRAC_W-1:0]  r_frac, n_frac;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [PACC_W-1:0]  r_pacc, n_pacc;
    logic [WACC_W-1:0]  r_wacc, n_wacc;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_vld, n_out_vld;
    logic [MAX_BINS-1:0] r_acc_vld, n_acc_vld;
    logic               r_vld_rd;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic [BIN_W-1:0]   len_c, pos1, nb, c0;
    logic [POWER_W-1:0] np;
    logic               upd, in_xfer, passed;
    logic [ADDR_W-1:0]  wk_addr, acc_raddr;
    logic               row_we, acc_we;
    logic [POWER_W-1:0] row_rdata;
    logic [PACC_W-1:0]  pacc_rdata, pacc_wdata, ps;
    logic [WACC_W-1:0]  wacc_rdata, wacc_wdata, ws;
    logic [PACC_W:0]    psum;
    logic [WACC_W:0]    wsum;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign wk_addr   = ADDR_W'(r_centre - BIN_W'(1) + BIN_W'(r_k));
    assign acc_raddr = (r_state == S_IDLE) ? ADDR_W'(i_in.read_bin) : wk_addr;
    assign row_we    = in_xfer && (i_in.action == ACT_PUSH) && (r_pos < BIN_W'(MAX_BINS));
    assign acc_we    = (r_state == S_UPD);
    assign psum      = {1'b0, r_pacc} + (PACC_W+1)'(r_prod);
    assign wsum      = {1'b0, r_wacc} + (WACC_W+1)'(r_frac);
    assign pacc_wdata = psum[PACC_W] ? '1 : psum[PACC_W-1:0];
    assign wacc_wdata = wsum[WACC_W] ? '1 : wsum[WACC_W-1:0];
    assign ps        = r_vld_rd ? pacc_rdata : '0;
    assign ws        = r_vld_rd ? wacc_rdata : '0;

    always_comb begin
        if (r_row_len < BIN_W'(3)) begin
            len_c = BIN_W'(3);
        end else if (r_row_len > BIN_W'(MAX_BINS)) begin
            len_c = BIN_W'(MAX_BINS);
        end else begin
            len_c = r_row_len;
        end
    end

    // running peak including the bin now being pushed
    assign upd    = (r_pos != '0) && (i_in.bin_power > r_pk_pow);
    assign nb     = upd ? r_pos : r_pk_bin;
    assign np     = upd ? i_in.bin_power : r_pk_pow;
    assign pos1   = r_pos + BIN_W'(1);
    assign passed = np > r_thresh;
    assign c0     = (nb == '0) ? BIN_W'(1) : nb;

    spwa_ram #(.WIDTH(POWER_W), .DEPTH(MAX_BINS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (ADDR_W'(r_pos)),
        .i_wdata (i_in.bin_power),
        .i_raddr (wk_addr),
        .o_rdata (row_rdata)
    );

    spwa_ram #(.WIDTH(PACC_W), .DEPTH(MAX_BINS)) u_pacc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (wk_addr),
        .i_wdata (pacc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (pacc_rdata)
    );

    spwa_ram #(.WIDTH(WACC_W), .DEPTH(MAX_BINS)) u_wacc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (wk_addr),
        .i_wdata (wacc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (wacc_rdata)
    );

    spwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_pk_bin  = r_pk_bin;
        n_pk_pow  = r_pk_pow;
        n_centre  = r_centre;
        n_k       = r_k;
        n_sum     = r_sum;
        n_x       = r_x;
        n_frac    = r_frac;
        n_prod    = r_prod;
        n_pacc    = r_pacc;
        n_wacc    = r_wacc;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_out.ready;
        n_acc_vld = r_acc_vld;
        div_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res      = '0;
                    if (i_in.action == ACT_READ) begin
                        n_res.kind = KIND_READOUT;
                        if (i_in.read_bin < BIN_W'(MAX_BINS)) begin
                            n_state = S_RD_DATA;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end else if (pos1 >= len_c) begin
                        n_res.kind        = KIND_REPORT;
                        n_res.peak_bin    = nb;
                        n_res.peak_power  = np;
                        n_res.peak_passed = passed;
                        n_pos    = '0;
                        n_pk_bin = '0;
                        n_pk_pow = '0;
                        // keep the three-bin window inside the row
                        n_centre = (c0 >= pos1 - BIN_W'(1)) ? pos1 - BIN_W'(2) : c0;
                        n_k      = '0;
                        n_sum    = '0;
                        n_state  = passed ? S_SUM_ADDR : S_EMIT;
                    end else begin
                        n_pos    = pos1;
                        n_pk_bin = nb;
                        n_pk_pow = np;
                    end
                end
            end
            S_SUM_ADDR: begin
                n_state = S_SUM_DATA;
            end
            S_SUM_DATA: begin
                n_sum = r_sum + SUM_W'(row_rdata);
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_FR_ADDR;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_SUM_ADDR;
                end
            end
            S_FR_ADDR: begin
                n_state = S_FR_DATA;
            end
            S_FR_DATA: begin
                n_x    = row_rdata;
                n_pacc = ps;
                n_wacc = ws;
                if (r_sum == '0) begin
                    n_frac  = '0;
                    n_state = S_MUL;
                end else if (SUM_W'(row_rdata) >= r_sum) begin
                    n_frac  = '1;
                    n_state = S_MUL;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem   = REM_W'(row_rdata);
                    div_req.dvd   = '0;
                    div_req.dvs   = WACC_W'(r_sum);
                    div_req.steps = STEP_W'(FRAC_W);
                    n_state       = S_FR_DIV;
                end
            end
            S_FR_DIV: begin
                if (div_rsp.done) begin
                    n_frac  = div_rsp.quot[FRAC_W-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = r_x * r_frac;
                n_state = S_UPD;
            end
            S_UPD: begin
                n_acc_vld[wk_addr] = 1'b1;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_FR_ADDR;
                end
            end
            S_RD_DATA: begin
                n_res.weighted_power_sum = ps;
                n_res.weight_sum         = ws;
                if (ws == '0) begin
                    n_res.mean_power = '0;
                    n_state          = S_EMIT;
                end else if (WACC_W'(ps[PACC_W-1:MEAN_W]) >= ws) begin
                    // quotient needs more than the mean width
                    n_res.mean_power = '1;
                    n_state          = S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem   = REM_W'(ps[PACC_W-1:MEAN_W]);
                    div_req.dvd   = ps[MEAN_W-1:0];
                    div_req.dvs   = ws;
                    div_req.steps = STEP_W'(MEAN_W);
                    n_state       = S_RD_DIV;
                end
            end
            S_RD_DIV: begin
                if (div_rsp.done) begin
                    n_res.mean_power = div_rsp.quot;
                    n_state          = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_thresh  <= POWER_W'(1000);
            r_row_len <= BIN_W'(MAX_BINS);
            r_pos     <= '0;
            r_pk_bin  <= '0;
            r_pk_pow  <= '0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
            r_acc_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_pk_bin  <= n_pk_bin;
            r_pk_pow  <= n_pk_pow;
            r_k       <= n_k;
            r_out_vld <= n_out_vld;
            r_acc_vld <= n_acc_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_THRESHOLD:  r_thresh  <= i_cfg_data[POWER_W-1:0];
                    REG_ROW_LENGTH: r_row_len <= i_cfg_data[BIN_W-1:0];
                    default: ;
                endcase
            end
        end
        r_centre <= n_centre;
        r_sum    <= n_sum;
        r_x      <= n_x;
        r_frac   <= n_frac;
        r_prod   <= n_prod;
        r_pacc   <= n_pacc;
        r_wacc   <= n_wacc;
        r_res    <= n_res;
        r_out    <= n_out;
        r_vld_rd <= r_acc_vld[acc_raddr];
    end

    assign o_out.valid              = r_out_vld;
    assign o_out.kind               = r_out.kind;
    assign o_out.peak_bin           = r_out.peak_bin;
    assign o_out.peak_power         = r_out.peak_power;
    assign o_out.peak_passed        = r_out.peak_passed;
    assign o_out.weighted_power_sum = r_out.weighted_power_sum;
    assign o_out.weight_sum         = r_out.weight_sum;
    assign o_out.mean_power         = r_out.mean_power;
endmodule

// ===== rtl/core/spwa_ram.sv =====
// spwa_ram: generic single write port, single read port ram with registered read
// no dependencies
module spwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 129
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/spwa_div.sv =====
// spwa_div: shared restoring divider, one quotient bit per cycle
// depends on spwa_pkg for the request and response types
module spwa_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spwa_pkg::t_div_req  i_req,
    output spwa_pkg::t_div_rsp  o_rsp
);
    import spwa_pkg::*;

    logic [REM_W-1:0]  r_rem, n_rem;
    logic [MEAN_W-1:0] r_dvd, n_dvd;
    logic [WACC_W-1:0] r_dvs, n_dvs;
    logic [MEAN_W-1:0] r_quot, n_quot;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [REM_W-1:0]  shifted;
    logic              ge;

    always_comb begin
        shifted = {r_rem[REM_W-2:0], r_dvd[MEAN_W-1]};
        ge      = shifted >= {1'b0, r_dvs};
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        n_quot  = r_quot;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.rem;
            n_dvd  = i_req.dvd;
            n_dvs  = i_req.dvs;
            n_quot = '0;
            n_cnt  = i_req.steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = ge ? shifted - {1'b0, r_dvs} : shifted;
            n_dvd  = {r_dvd[MEAN_W-2:0], 1'b0};
            n_quot = {r_quot[MEAN_W-2:0], ge};
            n_cnt  = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
        r_cnt  <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

// ===== tb/sv/spwa_result_checker.sv =====
`timescale 1ns / 100ps
// spwa_result_checker: watches the bin and result channels and the register port,
// predicts each peak report and readout, and compares them. depends on spwa_pkg,
// spwa_in_if and spwa_out_if
module spwa_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    spwa_in_if                              i_in_mon,
    spwa_out_if                             i_out_mon,
    input  logic                            i_cfg_we,
    input  logic [spwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spwa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results
);
    import spwa_pkg::*;

    logic [POWER_W-1:0] thr_q;
    logic [BIN_W-1:0]   row_len_q;
    logic [POWER_W-1:0] row_bins [MAX_BINS];
    logic [PACC_W-1:0]  pwr_acc [MAX_BINS];
    logic [WACC_W-1:0]  wgt_acc [MAX_BINS];
    int                 bin_pos;
    int                 best_bin;
    logic [POWER_W-1:0] best_pwr;
    t_result            expected_q[$];

    function automatic logic [FRAC_W-1:0] bin_fraction(logic [POWER_W-1:0] x,
                                                       logic [SUM_W-1:0] total);
        logic [PROD_W+1:0] q;
        if (total == '0) return '0;
        if ({2'b00, x} >= total) return '1;
        q = {x, {FRAC_W{1'b0}}} / total;
        return (q > {FRAC_W{1'b1}}) ? '1 : q[FRAC_W-1:0];
    endfunction

    task automatic predict_item(input logic act, input logic [POWER_W-1:0] pw,
                                input logic [BIN_W-1:0] rb);
        t_result             r;
        int                  len;
        int                  n;
        int                  c;
        logic [SUM_W-1:0]    total;
        logic [FRAC_W-1:0]   f;
        logic [PACC_W:0]     ps;
        logic [WACC_W:0]     ws;
        logic [PACC_W-1:0]   m;
        r = '0;
        if (act == ACT_READ) begin
            r.kind = KIND_READOUT;
            if (rb < MAX_BINS) begin
                r.weighted_power_sum = pwr_acc[rb];
                r.weight_sum = wgt_acc[rb];
                if (wgt_acc[rb] != '0) begin
                    m = pwr_acc[rb] / wgt_acc[rb];
                    r.mean_power = (m > 64'hFFFF_FFFF) ? '1 : m[MEAN_W-1:0];
                end
            end
            expected_q.push_back(r);
            return;
        end
        len = row_len_q;
        if (len < 3) len = 3;
        if (len > MAX_BINS) len = MAX_BINS;
        if (bin_pos < MAX_BINS) row_bins[bin_pos] = pw;
        if (bin_pos >= 1 && pw > best_pwr) begin
            best_pwr = pw;
            best_bin = bin_pos;
        end
        bin_pos++;
        if (bin_pos < len) return;
        n = bin_pos;
        r.kind = KIND_REPORT;
        r.peak_bin = best_bin[BIN_W-1:0];
        r.peak_power = best_pwr;
        r.peak_passed = best_pwr > thr_q;
        if (r.peak_passed) begin
            c = best_bin;
            if (c == 0) c = 1;
            if (c >= n - 1) c = n - 2;
            total = row_bins[c-1] + row_bins[c] + row_bins[c+1];
            for (int k = c - 1; k <= c + 1; k++) begin
                f = bin_fraction(row_bins[k], total);
                ps = pwr_acc[k] + row_bins[k] * f;
                ws = wgt_acc[k] + f;
                pwr_acc[k] = ps[PACC_W] ? '1 : ps[PACC_W-1:0];
                wgt_acc[k] = ws[WACC_W] ? '1 : ws[WACC_W-1:0];
            end
        end
        bin_pos = 0;
        best_bin = 0;
        best_pwr = '0;
        expected_q.push_back(r);
    endtask

    task automatic compare_result();
        t_result e;
        if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected, kind %0d", i_out_mon.kind);
            o_fail_count++;
            return;
        end
        e = expected_q.pop_front();
        o_results++;
        if (i_out_mon.kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, i_out_mon.kind);
            o_fail_count++;
        end
        if (i_out_mon.peak_bin !== e.peak_bin) begin
            $error("peak_bin: expected %0d, got %0d", e.peak_bin, i_out_mon.peak_bin);
            o_fail_count++;
        end
        if (i_out_mon.peak_power !== e.peak_power) begin
            $error("peak_power: expected %0h, got %0h", e.peak_power, i_out_mon.peak_power);
            o_fail_count++;
        end
        if (i_out_mon.peak_passed !== e.peak_passed) begin
            $error("peak_passed: expected %0d, got %0d", e.peak_passed, i_out_mon.peak_passed);
            o_fail_count++;
        end
        if (i_out_mon.weighted_power_sum !== e.weighted_power_sum) begin
            $error("weighted_power_sum: expected %0h, got %0h", e.weighted_power_sum,
                   i_out_mon.weighted_power_sum);
            o_fail_count++;
        end
        if (i_out_mon.weight_sum !== e.weight_sum) begin
            $error("weight_sum: expected %0h, got %0h", e.weight_sum, i_out_mon.weight_sum);
            o_fail_count++;
        end
        if (i_out_mon.mean_power !== e.mean_power) begin
            $error("mean_power: expected %0h, got %0h", e.mean_power, i_out_mon.mean_power);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_results = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_q = 32'd1000;
            row_len_q = 8'd129;
            bin_pos = 0;
            best_bin = 0;
            best_pwr = '0;
            for (int k = 0; k < MAX_BINS; k++) begin
                row_bins[k] = '0;
                pwr_acc[k] = '0;
                wgt_acc[k] = '0;
            end
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_THRESHOLD) thr_q = i_cfg_data;
                else if (i_cfg_idx == REG_ROW_LENGTH) row_len_q = i_cfg_data[BIN_W-1:0];
            end
            // compare first so a result can never match an item taken at the same edge
            if (i_out_mon.valid && i_out_mon.ready) compare_result();
            if (i_in_mon.valid && i_in_mon.ready)
                predict_item(i_in_mon.action, i_in_mon.bin_power, i_in_mon.read_bin);
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== tb/sv/spectrum_peak_weighted_accumulator_tb.sv =====
`timescale 1ns / 100ps
// spectrum_peak_weighted_accumulator_tb: drives bin rows, reads and register writes
// into the block with bursty traffic and a stalling receiver. depends on spwa_pkg,
// the channel interfaces, the block and spwa_result_checker
module spectrum_peak_weighted_accumulator_tb;
    import spwa_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES  = 500;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    results_seen;
    int                    items_sent;
    int                    burst_left;
    int                    idle_cycles;
    int                    phases;
    logic                  hold_req;

    spwa_in_if  bin_ch ();
    spwa_out_if res_ch ();

    spectrum_peak_weighted_accumulator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (bin_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    spwa_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (bin_ch),
        .i_out_mon    (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((bin_ch.valid && bin_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: stall pattern picked at random from three modes, plus one long hold-off
    initial begin
        int mode;
        int left;
        res_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = 50;
                end
                left--;
                case (mode)
                    0:       res_ch.ready = 1'b1;
                    1:       res_ch.ready = 1'($urandom_range(0, 1));
                    default: res_ch.ready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic act, input logic [POWER_W-1:0] pw,
                             input logic [BIN_W-1:0] rb);
        int gap;
        if (burst_left == 0) begin
            bin_ch.valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        bin_ch.valid = 1'b1;
        bin_ch.action = act;
        bin_ch.bin_power = pw;
        bin_ch.read_bin = rb;
        do @(posedge i_clk); while (!bin_ch.ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic push_row3(input logic [POWER_W-1:0] a, input logic [POWER_W-1:0] b,
                             input logic [POWER_W-1:0] c);
        send_item(ACT_PUSH, a, '0);
        send_item(ACT_PUSH, b, '0);
        send_item(ACT_PUSH, c, '0);
    endtask

    // waits for every result, then lets the block settle
    task automatic wait_quiet();
        bin_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [POWER_W-1:0] rand_power();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 2000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n_items;
        bin_ch.valid = 1'b0;
        bin_ch.action = ACT_PUSH;
        bin_ch.bin_power = '0;
        bin_ch.read_bin = '0;
        cfg_we = 1'b0;
        cfg_idx = REG_THRESHOLD;
        cfg_data = '0;
        hold_req = 1'b0;
        items_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        phases = 0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: shortest rows, threshold at both ends, edge bins
        write_reg(REG_ROW_LENGTH, 32'd3);
        write_reg(REG_THRESHOLD, 32'd0);
        push_row3(32'd0, 32'd0, 32'd0);
        push_row3(32'hFFFF_FFFF, 32'd0, 32'd0);
        push_row3(32'd5, 32'hFFFF_FFFF, 32'd7);
        push_row3(32'd1, 32'd2, 32'd9);
        push_row3(32'd0, 32'd5, 32'd5);
        push_row3(32'd0, 32'd7, 32'd0);
        send_item(ACT_READ, '0, 8'd0);
        send_item(ACT_READ, '0, 8'd1);
        send_item(ACT_READ, '0, 8'd2);
        send_item(ACT_READ, '0, 8'd128);
        send_item(ACT_READ, '0, 8'd255);
        wait_quiet();
        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        push_row3(32'd0, 32'hFFFF_FFFF, 32'd0);
        wait_quiet();
        write_reg(REG_ROW_LENGTH, 32'd0);
        push_row3(32'd3, 32'd4, 32'd5);

        // random phases; partial rows left at a phase end meet the next row length
        while (items_sent < 770) begin
            wait_quiet();
            phases++;
            case ($urandom_range(0, 4))
                0:       write_reg(REG_THRESHOLD, 32'd0);
                1:       write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
                2:       write_reg(REG_THRESHOLD, $urandom_range(0, 3000));
                default: write_reg(REG_THRESHOLD, $urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(REG_ROW_LENGTH, 32'd129);
                1:       write_reg(REG_ROW_LENGTH, $urandom_range(0, 255));
                2:       write_reg(REG_ROW_LENGTH, $urandom_range(0, 2));
                default: write_reg(REG_ROW_LENGTH, $urandom_range(3, 12));
            endcase
            n_items = $urandom_range(10, 60);
            if (phases == 3) begin
                hold_req = 1'b1;
                n_items = 40;
            end
            repeat (n_items) begin
                if ($urandom_range(0, 99) < 12)
                    send_item(ACT_READ, $urandom, ($urandom_range(0, 3) == 0) ?
                              BIN_W'($urandom_range(0, 255)) :
                              BIN_W'($urandom_range(0, MAX_BINS + 2)));
                else
                    send_item(ACT_PUSH, rand_power(), BIN_W'($urandom));
            end
        end

        bin_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("covered %0d items over %0d register phases, %0d results checked",
                 items_sent, phases, results_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
